// ===== rtl/fixed_length_frame_deframer_unit_assert.svh =====
// Assertion macros shared by the frame deframer modules.
`ifndef FIXED_LENGTH_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define FIXED_LENGTH_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fld_pkg.sv =====
// Shared constants and types of the fixed-length frame deframer.
package fld_pkg;

    localparam int DATA_W          = 8;
    localparam int IDX_W           = 6;
    localparam int PAYLOAD_LEN_DEF = 48;
    localparam int CFG_IDX_W       = 2;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 16;

    localparam logic [DATA_W-1:0] START_FIRST_RST  = 8'h55;
    localparam logic [DATA_W-1:0] START_SECOND_RST = 8'hAA;
    localparam logic [DATA_W-1:0] END_FIRST_RST    = 8'hAA;
    localparam logic [DATA_W-1:0] END_SECOND_RST   = 8'h55;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_FIRST  = 2'd0,
        CFG_START_SECOND = 2'd1,
        CFG_END_FIRST    = 2'd2,
        CFG_END_SECOND   = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_HUNT1 = 5'b00001,
        ST_HUNT2 = 5'b00010,
        ST_FILL  = 5'b00100,
        ST_END1  = 5'b01000,
        ST_END2  = 5'b10000
    } t_state;

endpackage

// ===== rtl/fld_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fld_drain.sv =====
// Read sequencer that streams a stored payload out of the RAM, one byte per read.
module fld_drain #(
    parameter int PAYLOAD_LEN = fld_pkg::PAYLOAD_LEN_DEF,
    parameter int AW          = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    output logic                      o_re,
    output logic [AW-1:0]             o_raddr,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [fld_pkg::IDX_W-1:0] o_idx,
    output logic                      o_last
);
    import fld_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

    logic             r_busy;
    logic             n_busy;
    logic [IDX_W-1:0] r_rd_cnt;
    logic [IDX_W-1:0] n_rd_cnt;
    logic             r_valid;
    logic             n_valid;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_last;
    logic             n_last;
    logic             rd_issue;
    logic             rd_final;

    // A read may go out when the output slot is free or is being emptied this cycle.
    // The RAM output register then holds the byte until the transaction completes.
    assign rd_issue = r_busy && (!r_valid || i_ready);
    assign rd_final = (r_rd_cnt == LAST_IDX);

    always_comb begin
        n_busy   = r_busy;
        n_rd_cnt = r_rd_cnt;
        n_valid  = r_valid;
        n_idx    = r_idx;
        n_last   = r_last;
        if (i_start) begin
            n_busy   = 1'b1;
            n_rd_cnt = '0;
        end
        if (rd_issue) begin
            n_valid = 1'b1;
            n_idx   = r_rd_cnt;
            n_last  = rd_final;
            if (rd_final) begin
                n_busy = 1'b0;
            end else begin
                n_rd_cnt = r_rd_cnt + 1'b1;
            end
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_cnt <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_rd_cnt <= n_rd_cnt;
            r_valid  <= n_valid;
        end
        r_idx  <= n_idx;
        r_last <= n_last;
    end

    assign o_busy  = r_busy;
    assign o_re    = rd_issue;
    assign o_raddr = r_rd_cnt[AW-1:0];
    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_last  = r_last;

`include "fixed_length_frame_deframer_unit_assert.svh"

    `FLD_ASSERT_NOW(a_start_idle, i_start, !r_busy, "drain started while busy")
    `FLD_ASSERT_NOW(a_cnt_range, r_busy, r_rd_cnt <= LAST_IDX, "read count out of range")
    `FLD_ASSERT_NEXT(a_final_read, rd_issue && rd_final,
        !r_busy && r_valid && r_last && (r_idx == LAST_IDX), "final read not marked last")

endmodule

// ===== rtl/fixed_length_frame_deframer_unit.sv =====
// Fixed-length frame deframer: sync hunt, payload capture in RAM and frame drain.
// The block accepts one received byte per cycle while it hunts, stores and checks
// a frame. A byte that completes a good end mark starts a drain of PAYLOAD_LEN
// stored bytes through the single RAM read port, one output transaction per cycle
// when the sink is ready; input is held off until the last read has been issued,
// so a valid frame spans PAYLOAD_LEN + 4 input bytes followed by its drain.
// Configuration is taken at any cycle with i_cfg_we high and should only
// change while no frame is in progress. Output tdata carries frame_byte in bits
// 7:0 and byte_index in bits 13:8; tlast marks the final payload byte.
module fixed_length_frame_deframer_unit #(
    parameter int PAYLOAD_LEN = fld_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fld_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fld_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: rx_byte [7:0]
    input  logic [fld_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: frame_byte [7:0], byte_index [13:8], zero [15:14]
    output logic [fld_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);
    import fld_pkg::*;

    localparam int               AW       = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

    logic [DATA_W-1:0] r_start_first;
    logic [DATA_W-1:0] r_start_second;
    logic [DATA_W-1:0] r_end_first;
    logic [DATA_W-1:0] r_end_second;

    t_state            r_state;
    t_state            n_state;
    logic [IDX_W-1:0]  r_fill;
    logic [IDX_W-1:0]  n_fill;

    logic              in_acc;
    logic [DATA_W-1:0] rx_byte;
    logic              ram_we;
    logic              drain_start;
    logic              drain_busy;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [IDX_W-1:0]  out_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_first  <= START_FIRST_RST;
            r_start_second <= START_SECOND_RST;
            r_end_first    <= END_FIRST_RST;
            r_end_second   <= END_SECOND_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_FIRST:  r_start_first  <= i_cfg_data;
                CFG_START_SECOND: r_start_second <= i_cfg_data;
                CFG_END_FIRST:    r_end_first    <= i_cfg_data;
                CFG_END_SECOND:   r_end_second   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = !drain_busy;
    assign in_acc          = i_s_axis_tvalid && !drain_busy;
    assign rx_byte         = i_s_axis_tdata[DATA_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        ram_we      = 1'b0;
        drain_start = 1'b0;
        if (in_acc) begin
            case (r_state)
                ST_HUNT1: begin
                    n_state = (rx_byte == r_start_first) ? ST_HUNT2 : ST_HUNT1;
                end
                ST_HUNT2: begin
                    // A match on the second start byte wins over a repeat of the first.
                    if (rx_byte == r_start_second) begin
                        n_fill  = '0;
                        n_state = ST_FILL;
                    end else if (rx_byte != r_start_first) begin
                        n_state = ST_HUNT1;
                    end
                end
                ST_FILL: begin
                    ram_we = 1'b1;
                    if (r_fill == LAST_IDX) begin
                        n_fill  = '0;
                        n_state = ST_END1;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
                ST_END1: begin
                    n_state = (rx_byte == r_end_first) ? ST_END2 : ST_HUNT1;
                end
                ST_END2: begin
                    drain_start = (rx_byte == r_end_second);
                    n_state     = ST_HUNT1;
                end
                default: begin
                    n_state = ST_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT1;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    fld_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PAYLOAD_LEN),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (rx_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fld_drain #(
        .PAYLOAD_LEN (PAYLOAD_LEN),
        .AW          (AW)
    ) u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (drain_start),
        .o_busy  (drain_busy),
        .o_re    (ram_re),
        .o_raddr (ram_raddr),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_idx   (out_idx),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W - DATA_W - IDX_W){1'b0}}, out_idx, ram_rdata};

`include "fixed_length_frame_deframer_unit_assert.svh"

    `FLD_ASSERT_NOW(a_no_fill_in_drain, ram_we, !drain_busy && !ram_re,
        "payload write while draining")
    `FLD_ASSERT_NOW(a_start_on_end2, drain_start, r_state == ST_END2,
        "drain started outside end mark check")
    `FLD_ASSERT_NOW(a_fill_range, r_state == ST_FILL, r_fill <= LAST_IDX,
        "fill count out of range")

endmodule
